// File: design/evi_pkg.sv
package evi_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned FRAC_W     = 12;
  localparam int unsigned COEF_W     = 12;
  localparam int unsigned BND_W      = 14;
  localparam int unsigned LUT_W      = 13;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned TIDX_W     = 12;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned PROD_W     = COEF_W + SAMPLE_W;
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned DIV_W      = 24;
  localparam int unsigned REM_W      = 43;
  localparam int unsigned DVS_W      = 24;
  localparam int unsigned QUO_W      = 19;
  localparam int unsigned Q2_BITS    = 12;
  localparam int unsigned SH_W       = 5;
  localparam int unsigned POST_STG   = 3;
  localparam int unsigned N_STG      = 2 + QUO_W + POST_STG + Q2_BITS;

  localparam logic signed [BND_W-1:0] BND_ONE  = BND_W'(4096);
  localparam logic signed [BND_W-1:0] BND_MONE = -BND_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN,
    CFG_RED_COEF,
    CFG_BLUE_COEF,
    CFG_CANOPY,
    CFG_SOIL,
    CFG_RANGE_MIN,
    CFG_RANGE_MAX,
    CFG_LUT_SIZE
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] nir_sample;
    logic [SAMPLE_W-1:0] red_sample;
    logic [SAMPLE_W-1:0] blue_sample;
  } pix_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] index_value;
    logic                    zero_divisor;
    logic                    in_range;
    logic [TIDX_W-1:0]       table_index;
    logic [COL_W-1:0]        colour_level;
  } res_t;

  typedef struct packed {
    logic [COEF_W-1:0]       gain;
    logic [COEF_W-1:0]       red_coef;
    logic [COEF_W-1:0]       blue_coef;
    logic [COEF_W-1:0]       canopy_offset;
    logic                    soil_mode;
    logic signed [BND_W-1:0] range_min;
    logic signed [BND_W-1:0] range_max;
    logic [LUT_W-1:0]        lut_size;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] v;
    logic                    zero;
    logic                    neg;
    logic                    ovf;
    logic                    in_range;
    logic [COL_W-1:0]        colour;
    logic                    pos;
  } tag_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
    tag_t             tag;
  } div_t;

  function automatic logic signed [BND_W-1:0] bound_clamp(logic signed [BND_W-1:0] b);
    logic signed [BND_W-1:0] r;
    r = b;
    if (b < BND_MONE) r = BND_MONE;
    if (b > BND_ONE) r = BND_ONE;
    return r;
  endfunction

  function automatic logic signed [BND_W-1:0] lo_bound(cfg_t c);
    logic signed [BND_W-1:0] lo;
    logic signed [BND_W-1:0] hi;
    lo = bound_clamp(c.range_min);
    hi = bound_clamp(c.range_max);
    return (lo == hi) ? BND_MONE : lo;
  endfunction

  function automatic logic signed [BND_W-1:0] hi_bound(cfg_t c);
    logic signed [BND_W-1:0] lo;
    logic signed [BND_W-1:0] hi;
    lo = bound_clamp(c.range_min);
    hi = bound_clamp(c.range_max);
    return (lo == hi) ? BND_ONE : hi;
  endfunction

  // Top table position, lut_size - 1 after clamping the size to 1..4096
  function automatic logic [TIDX_W-1:0] lut_w(logic [LUT_W-1:0] ls);
    logic [TIDX_W-1:0] w;
    if (ls == '0) begin
      w = '0;
    end else if (ls > LUT_W'(1 << TIDX_W)) begin
      w = '1;
    end else begin
      w = TIDX_W'(ls - LUT_W'(1));
    end
    return w;
  endfunction

endpackage

// File: design/enhanced_vegetation_index_pixel.sv
// Enhanced vegetation index, one pixel per item.
// Input channel: in_valid_i / in_stall_o with the three band samples in
// in_data_i. Output channel: out_valid_o / out_stall_i with the index value,
// zero-divisor flag, range flag, table position and colour level in out_data_o.
// Configuration: write cfg_data_i to register cfg_index_i while cfg_we_i is
// high; write only while no item is in flight.
// Throughput: one item per cycle while the skid entry is empty. The pipeline
// is a row of cells: two front stages (products, then sums), 19
// restoring-division cells for the index quotient, three post stages
// (saturation, range/colour/table product, operand setup) and 12 division
// cells for the table position; each cell retires one bit.
// Reset: all valid bits clear, registers take their default coefficients.
// Stall: the output register plus one skid entry let the pipe keep taking
// items while a result waits; once the skid entry fills, the whole pipe
// holds and in_stall_o rises until the receiver takes an item.
module enhanced_vegetation_index_pixel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  evi_pkg::pix_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output evi_pkg::res_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [evi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [evi_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  evi_pkg::cfg_t cfg_q;
  logic [evi_pkg::N_STG-1:0] vld_q;
  logic adv, pop, arrive;
  logic out_vld_q, skid_vld_q;
  evi_pkg::res_t out_q, skid_q, res_new;
  logic [evi_pkg::TIDX_W-1:0] w;

  evi_pkg::div_t c1 [evi_pkg::QUO_W+1];
  evi_pkg::div_t c2 [evi_pkg::Q2_BITS+1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain          <= 12'd640;
      cfg_q.red_coef      <= 12'd1536;
      cfg_q.blue_coef     <= 12'd1920;
      cfg_q.canopy_offset <= 12'd256;
      cfg_q.soil_mode     <= 1'b0;
      cfg_q.range_min     <= evi_pkg::BND_MONE;
      cfg_q.range_max     <= evi_pkg::BND_ONE;
      cfg_q.lut_size      <= 13'd256;
    end else if (cfg_we_i) begin
      unique case (evi_pkg::cfg_idx_e'(cfg_index_i))
        evi_pkg::CFG_GAIN:      cfg_q.gain          <= cfg_data_i[11:0];
        evi_pkg::CFG_RED_COEF:  cfg_q.red_coef      <= cfg_data_i[11:0];
        evi_pkg::CFG_BLUE_COEF: cfg_q.blue_coef     <= cfg_data_i[11:0];
        evi_pkg::CFG_CANOPY:    cfg_q.canopy_offset <= cfg_data_i[11:0];
        evi_pkg::CFG_SOIL:      cfg_q.soil_mode     <= cfg_data_i[0];
        evi_pkg::CFG_RANGE_MIN: cfg_q.range_min     <= $signed(cfg_data_i);
        evi_pkg::CFG_RANGE_MAX: cfg_q.range_max     <= $signed(cfg_data_i);
        evi_pkg::CFG_LUT_SIZE:  cfg_q.lut_size      <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // the whole row advances unless the skid entry is occupied
  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[evi_pkg::N_STG-2:0], in_valid_i};
    end
  end

  evi_front u_front (
    .clk_i (clk_i),
    .en_i  (adv),
    .cfg_i (cfg_q),
    .pix_i (in_data_i),
    .d_o   (c1[0])
  );

  for (genvar k = 0; k < evi_pkg::QUO_W; k++) begin : g_div1
    evi_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .sh_i  (evi_pkg::SH_W'(evi_pkg::QUO_W - 1 - k)),
      .d_i   (c1[k]),
      .d_o   (c1[k+1])
    );
  end

  evi_post u_post (
    .clk_i (clk_i),
    .en_i  (adv),
    .cfg_i (cfg_q),
    .d_i   (c1[evi_pkg::QUO_W]),
    .d_o   (c2[0])
  );

  for (genvar k = 0; k < evi_pkg::Q2_BITS; k++) begin : g_div2
    evi_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .sh_i  (evi_pkg::SH_W'(evi_pkg::Q2_BITS - 1 - k)),
      .d_i   (c2[k]),
      .d_o   (c2[k+1])
    );
  end

  // final result: clip the table position, drop everything on a zero divisor
  always_comb begin
    w       = evi_pkg::lut_w(cfg_q.lut_size);
    res_new = '0;
    res_new.zero_divisor = c2[evi_pkg::Q2_BITS].tag.zero;
    if (!c2[evi_pkg::Q2_BITS].tag.zero) begin
      res_new.index_value  = c2[evi_pkg::Q2_BITS].tag.v;
      res_new.in_range     = c2[evi_pkg::Q2_BITS].tag.in_range;
      res_new.colour_level = c2[evi_pkg::Q2_BITS].tag.colour;
      priority if (!c2[evi_pkg::Q2_BITS].tag.pos) begin
        res_new.table_index = '0;
      end else if (c2[evi_pkg::Q2_BITS].tag.ovf) begin
        res_new.table_index = w;
      end else if (c2[evi_pkg::Q2_BITS].quo[evi_pkg::TIDX_W-1:0] > w) begin
        res_new.table_index = w;
      end else begin
        res_new.table_index = c2[evi_pkg::Q2_BITS].quo[evi_pkg::TIDX_W-1:0];
      end
    end
  end

  assign pop    = out_vld_q && !out_stall_i;
  assign arrive = adv && vld_q[evi_pkg::N_STG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) skid_vld_q <= 1'b0;
    end else if (arrive) begin
      if (!out_vld_q || pop) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) out_q <= skid_q;
    end else if (arrive) begin
      if (!out_vld_q || pop) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid entry held without output item");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("skid entry filled while output was free");

  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.zero_divisor |->
      out_q.index_value == '0 && out_q.table_index == '0 && !out_q.in_range)
    else $error("zero divisor item carries data");

  a_tidx_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.table_index <= w) else $error("table position above top entry");

  a_reversed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (evi_pkg::lo_bound(cfg_q) > evi_pkg::hi_bound(cfg_q)) |-> !out_q.in_range)
    else $error("range flag set with reversed bounds");

endmodule

// File: design/evi_front.sv
module evi_front (
  input  logic               clk_i,
  input  logic               en_i,
  input  evi_pkg::cfg_t      cfg_i,
  input  evi_pkg::pix_t      pix_i,
  output evi_pkg::div_t      d_o
);

  logic [evi_pkg::SAMPLE_W-1:0]    nir_q;
  logic [evi_pkg::PROD_W-1:0]      pr_q, pb_q;
  logic signed [evi_pkg::NUM_W-1:0] pg_q;
  logic signed [evi_pkg::SAMPLE_W:0] diff;

  logic [evi_pkg::DIV_W-1:0]       div_u;
  logic [evi_pkg::DIV_W-1:0]       div_mag;
  logic [evi_pkg::NUM_W-1:0]       num_mag;
  logic [evi_pkg::DVS_W-1:0]       d2;
  logic [evi_pkg::REM_W-1:0]       n2;
  evi_pkg::div_t                   d_d, d_q;

  assign diff = $signed({1'b0, pix_i.nir_sample}) - $signed({1'b0, pix_i.red_sample});

  // products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nir_q <= pix_i.nir_sample;
      pr_q  <= cfg_i.red_coef * pix_i.red_sample;
      pb_q  <= cfg_i.blue_coef * pix_i.blue_sample;
      pg_q  <= $signed({1'b0, cfg_i.gain}) * diff;
    end
  end

  // divisor, numerator and rounding offset for the long division
  always_comb begin
    div_u   = evi_pkg::DIV_W'({nir_q, 8'b0}) + evi_pkg::DIV_W'(pr_q)
            - evi_pkg::DIV_W'(pb_q) + evi_pkg::DIV_W'(cfg_i.canopy_offset);
    div_mag = div_u[evi_pkg::DIV_W-1] ? (~div_u + 1'b1) : div_u;
    num_mag = pg_q[evi_pkg::NUM_W-1] ? evi_pkg::NUM_W'(-pg_q) : evi_pkg::NUM_W'(pg_q);
    n2      = (evi_pkg::REM_W'(num_mag) << (evi_pkg::FRAC_W + 1))
            + evi_pkg::REM_W'(div_mag);
    d2      = evi_pkg::DVS_W'(div_mag << 1);
    d_d              = '0;
    d_d.rem          = n2;
    d_d.dvs          = d2;
    d_d.tag.zero     = (div_u == '0);
    d_d.tag.neg      = pg_q[evi_pkg::NUM_W-1] ^ div_u[evi_pkg::DIV_W-1];
    d_d.tag.ovf      = n2 >= (evi_pkg::REM_W'(d2) << evi_pkg::QUO_W);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

// File: design/evi_div_cell.sv
module evi_div_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [evi_pkg::SH_W-1:0] sh_i,
  input  evi_pkg::div_t            d_i,
  output evi_pkg::div_t            d_o
);

  logic [evi_pkg::REM_W-1:0] step;
  evi_pkg::div_t             d_d, d_q;

  // one quotient bit: subtract the shifted divisor where it fits
  always_comb begin
    step = evi_pkg::REM_W'(d_i.dvs) << sh_i;
    d_d  = d_i;
    if (d_i.rem >= step) begin
      d_d.rem = d_i.rem - step;
      d_d.quo = d_i.quo | (evi_pkg::QUO_W'(1) << sh_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

// File: design/evi_post.sv
module evi_post (
  input  logic          clk_i,
  input  logic          en_i,
  input  evi_pkg::cfg_t cfg_i,
  input  evi_pkg::div_t d_i,
  output evi_pkg::div_t d_o
);

  localparam logic [evi_pkg::QUO_W-1:0] QCLAMP = evi_pkg::QUO_W'(1 << (evi_pkg::QUO_W - 1));

  logic [evi_pkg::QUO_W-1:0]         q1, qc;
  logic signed [evi_pkg::QUO_W:0]    qs;
  logic signed [evi_pkg::QUO_W+1:0]  sum;
  logic signed [evi_pkg::VAL_W-1:0]  v1_d, v1_q, v2_q;
  logic                              zero1_q, zero2_q, inr2_q;
  logic [evi_pkg::COL_W-1:0]         col2_q;

  logic signed [evi_pkg::BND_W-1:0]  lo, hi;
  logic signed [evi_pkg::BND_W:0]    delta;
  logic [evi_pkg::BND_W-1:0]         dmag;
  logic [evi_pkg::TIDX_W-1:0]        w;
  logic [evi_pkg::VAL_W:0]           mag;
  logic [27:0]                       colx;
  logic signed [17:0]                s;
  logic signed [30:0]                n_d, n2_q;
  logic [30:0]                       nmag;
  logic [evi_pkg::REM_W-1:0]         rem0;
  logic [evi_pkg::DVS_W-1:0]         dvs0;
  evi_pkg::div_t                     d_d, d_q;

  // signed quotient, soil offset, saturation
  always_comb begin
    q1  = d_i.tag.ovf ? '1 : d_i.quo;
    qc  = (q1 > QCLAMP) ? QCLAMP : q1;
    qs  = d_i.tag.neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    sum = (evi_pkg::QUO_W+2)'(qs)
        + (cfg_i.soil_mode ? $signed((evi_pkg::QUO_W+2)'({cfg_i.canopy_offset, 4'b0}))
                           : $signed((evi_pkg::QUO_W+2)'(0)));
    if (sum > $signed((evi_pkg::QUO_W+2)'(32767))) begin
      v1_d = 16'sh7fff;
    end else if (sum < -$signed((evi_pkg::QUO_W+2)'(32768))) begin
      v1_d = 16'sh8000;
    end else begin
      v1_d = evi_pkg::VAL_W'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q    <= v1_d;
      zero1_q <= d_i.tag.zero;
    end
  end

  // range flag, colour level and table numerator
  always_comb begin
    lo    = evi_pkg::lo_bound(cfg_i);
    hi    = evi_pkg::hi_bound(cfg_i);
    delta = (evi_pkg::BND_W+1)'(hi) - (evi_pkg::BND_W+1)'(lo);
    w     = evi_pkg::lut_w(cfg_i.lut_size);
    mag   = v1_q[evi_pkg::VAL_W-1] ? (evi_pkg::VAL_W+1)'(-(evi_pkg::VAL_W+1)'(v1_q))
                                   : (evi_pkg::VAL_W+1)'(v1_q);
    colx  = ({11'b0, mag} << 10) - {11'b0, mag} + 28'd2048;
    s     = (18'(v1_q) <<< 1) + 18'(delta);
    n_d   = $signed({1'b0, w}) * s;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v2_q    <= v1_q;
      zero2_q <= zero1_q;
      inr2_q  <= (v1_q >= 16'(lo)) && (v1_q <= 16'(hi));
      col2_q  <= colx[evi_pkg::FRAC_W +: evi_pkg::COL_W];
      n2_q    <= n_d;
    end
  end

  // operands of the table division, magnitudes with rounding offset
  always_comb begin
    dmag = delta[evi_pkg::BND_W] ? evi_pkg::BND_W'(-delta) : evi_pkg::BND_W'(delta);
    nmag = n2_q[30] ? 31'(-n2_q) : 31'(n2_q);
    rem0 = evi_pkg::REM_W'(nmag) + evi_pkg::REM_W'(dmag);
    dvs0 = evi_pkg::DVS_W'(dmag) << 1;
    d_d              = '0;
    d_d.rem          = rem0;
    d_d.dvs          = dvs0;
    d_d.tag.v        = v2_q;
    d_d.tag.zero     = zero2_q;
    d_d.tag.in_range = inr2_q;
    d_d.tag.colour   = col2_q;
    d_d.tag.pos      = (n2_q[30] == delta[evi_pkg::BND_W]);
    d_d.tag.ovf      = rem0 >= (evi_pkg::REM_W'(dvs0) << evi_pkg::Q2_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule
